[hw/rtl/gwr_pkg.sv]
package gwr_pkg;

  localparam int unsigned MaxWord = 32;
  localparam int unsigned IdxW    = $clog2(MaxWord);
  localparam int unsigned CntW    = $clog2(MaxWord + 1);
  localparam int unsigned LineW   = 12;

  localparam logic [LineW-1:0] LineMax      = '1;
  localparam logic [LineW-1:0] LineWidthRst = 12'd80;

  localparam logic [7:0] ChrTab = 8'h09;
  localparam logic [7:0] ChrLf  = 8'h0A;
  localparam logic [7:0] ChrCr  = 8'h0D;
  localparam logic [7:0] ChrSp  = 8'h20;

  typedef enum logic {
    CMD_TEXT = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    SEP_NONE = 2'd0,
    SEP_NL   = 2'd1,
    SEP_SP   = 2'd2
  } sep_e;

  typedef enum logic [1:0] {
    OSEL_NL   = 2'd0,
    OSEL_SP   = 2'd1,
    OSEL_WORD = 2'd2
  } out_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic     accept;
    logic     load;
    out_sel_e sel;
    logic     last;
    logic     advance;
    logic     tail_dec;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_is_text;
    sep_e sep;
    logic has_word;
    logic word_final;
    logic tail_nz;
    logic tail_final;
    logic out_free;
  } dp_sts_t;

endpackage

[hw/rtl/gwr_datapath.sv]
module gwr_datapath import gwr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LineW-1:0] cfg_wdata_i,
  input  logic [7:0]       s_axis_tdata,
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast,
  output logic             m_axis_tuser,
  input  ctrl_cmd_t        cmd_i,
  output dp_sts_t          sts_o
);

  logic [7:0]       mem [MaxWord];
  logic [7:0]       rdata_q;
  logic [IdxW-1:0]  idx_q, idx_d;

  logic [LineW-1:0] line_width_q;
  logic [CntW-1:0]  wl_q, wl_d;
  logic [LineW-1:0] ll_q, ll_d;
  logic [1:0]       nrun_q, nrun_d;
  logic             err_q, err_d;
  logic             flag_q, flag_d;
  sep_e             sep_q, sep_d;
  logic [CntW-1:0]  wcnt_q, wcnt_d;
  logic [1:0]       tail_q, tail_d;

  logic             m_valid_q, m_valid_d;
  logic [7:0]       m_data_q;
  logic             m_last_q;
  logic             m_user_q;

  cmd_e             in_cmd;
  logic             is_space;
  logic             has_word;
  logic [LineW:0]   sum_lw;
  logic [LineW:0]   sum_lw1;
  logic [LineW-1:0] ll_sat1;
  logic             nl_sep;
  logic             sp_sep;
  logic [LineW-1:0] ll_flush;
  logic             err_after;
  logic [1:0]       run_inc;
  logic             dbl;
  logic             store_wr;
  logic             out_free;
  logic [7:0]       out_byte;

  assign in_cmd   = cmd_e'(s_axis_tuser);
  assign is_space = (s_axis_tdata == ChrSp) ||
                    (s_axis_tdata >= ChrTab && s_axis_tdata <= ChrCr);

  // flush decision for the pending word
  assign has_word  = (wl_q != '0);
  assign sum_lw    = {1'b0, ll_q} + (LineW+1)'(wl_q);
  assign sum_lw1   = sum_lw + (LineW+1)'(1);
  assign ll_sat1   = (sum_lw1 > {1'b0, LineMax}) ? LineMax : sum_lw1[LineW-1:0];
  assign nl_sep    = has_word && (ll_q != '0) && (sum_lw >= {1'b0, line_width_q});
  assign sp_sep    = has_word && (ll_q != '0) && !nl_sep;
  assign ll_flush  = sp_sep ? ll_sat1 : LineW'(wl_q);
  assign err_after = err_q | (has_word && (LineW'(wl_q) > line_width_q));

  assign run_inc   = nrun_q + 2'((s_axis_tdata == ChrLf) ? 1 : 0);
  assign dbl       = (run_inc == 2'd2);

  assign store_wr  = cmd_i.accept && (in_cmd == CMD_TEXT) && !is_space &&
                     (wl_q < CntW'(MaxWord));

  always_comb begin
    wl_d   = wl_q;
    ll_d   = ll_q;
    nrun_d = nrun_q;
    err_d  = err_q;
    flag_d = flag_q;
    sep_d  = sep_q;
    wcnt_d = wcnt_q;
    tail_d = tail_q;
    if (cmd_i.accept) begin
      if (in_cmd == CMD_END) begin
        sep_d  = nl_sep ? SEP_NL : (sp_sep ? SEP_SP : SEP_NONE);
        wcnt_d = wl_q;
        tail_d = 2'd1;
        flag_d = err_after;
        wl_d   = '0;
        ll_d   = '0;
        nrun_d = '0;
        err_d  = 1'b0;
      end else if (is_space) begin
        sep_d  = nl_sep ? SEP_NL : (sp_sep ? SEP_SP : SEP_NONE);
        wcnt_d = wl_q;
        tail_d = dbl ? 2'd2 : 2'd0;
        flag_d = err_after;
        err_d  = err_after;
        wl_d   = '0;
        nrun_d = dbl ? 2'd0 : run_inc;
        if (dbl) begin
          ll_d = '0;
        end else if (has_word) begin
          ll_d = ll_flush;
        end
      end else begin
        nrun_d = '0;
        if (wl_q < CntW'(MaxWord)) begin
          wl_d = wl_q + CntW'(1);
        end else begin
          err_d = 1'b1;
        end
      end
    end
    if (cmd_i.tail_dec) begin
      tail_d = tail_q - 2'd1;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.accept) begin
      idx_d = '0;
    end else if (cmd_i.advance) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      mem[wl_q[IdxW-1:0]] <= s_axis_tdata;
    end
    rdata_q <= mem[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthRst;
      wl_q         <= '0;
      ll_q         <= '0;
      nrun_q       <= '0;
      err_q        <= 1'b0;
      flag_q       <= 1'b0;
      sep_q        <= SEP_NONE;
      wcnt_q       <= '0;
      tail_q       <= '0;
      idx_q        <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_width_q <= cfg_wdata_i;
      end
      wl_q      <= wl_d;
      ll_q      <= ll_d;
      nrun_q    <= nrun_d;
      err_q     <= err_d;
      flag_q    <= flag_d;
      sep_q     <= sep_d;
      wcnt_q    <= wcnt_d;
      tail_q    <= tail_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  // output register
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    unique case (cmd_i.sel)
      OSEL_NL:   out_byte = ChrLf;
      OSEL_SP:   out_byte = ChrSp;
      OSEL_WORD: out_byte = rdata_q;
      default:   out_byte = ChrLf;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_i.load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_data_q <= out_byte;
      m_last_q <= cmd_i.last;
      m_user_q <= flag_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

  assign sts_o.in_is_text = (in_cmd == CMD_TEXT) && !is_space;
  assign sts_o.sep        = sep_q;
  assign sts_o.has_word   = (wcnt_q != '0);
  assign sts_o.word_final = (idx_q == IdxW'(wcnt_q - CntW'(1)));
  assign sts_o.tail_nz    = (tail_q != 2'd0);
  assign sts_o.tail_final = (tail_q == 2'd1);
  assign sts_o.out_free   = out_free;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> out_free)
    else $error("output register loaded while occupied");

  a_wl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wl_q <= CntW'(MaxWord))
    else $error("word length beyond store depth");

  a_nrun_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> nrun_q != 2'd2 && nrun_q != 2'd3)
    else $error("newline run not folded");

endmodule

[hw/rtl/gwr_ctrl.sv]
module gwr_ctrl import gwr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PLAN = 5'b00010,
    ST_SEP  = 5'b00100,
    ST_WORD = 5'b01000,
    ST_TAIL = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.sel      = OSEL_NL;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          if (!sts_i.in_is_text) begin
            state_d = ST_PLAN;
          end
        end
      end
      ST_PLAN: begin
        if (sts_i.sep != SEP_NONE) begin
          state_d = ST_SEP;
        end else if (sts_i.has_word) begin
          state_d = ST_WORD;
        end else if (sts_i.tail_nz) begin
          state_d = ST_TAIL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SEP: begin
        // a separator is always followed by a word byte
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = (sts_i.sep == SEP_SP) ? OSEL_SP : OSEL_NL;
          state_d    = ST_WORD;
        end
      end
      ST_WORD: begin
        if (sts_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.sel     = OSEL_WORD;
          cmd_o.advance = 1'b1;
          cmd_o.last    = sts_i.word_final && !sts_i.tail_nz;
          if (sts_i.word_final) begin
            state_d = sts_i.tail_nz ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (sts_i.out_free) begin
          cmd_o.load     = 1'b1;
          cmd_o.sel      = OSEL_NL;
          cmd_o.tail_dec = 1'b1;
          cmd_o.last     = sts_i.tail_final;
          if (sts_i.tail_final) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_word_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WORD |-> sts_i.has_word)
    else $error("word emission with empty word");

  a_tail_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TAIL |-> sts_i.tail_nz)
    else $error("tail emission with no newline left");

  a_sep_then_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEP && sts_i.out_free) |=> state_q == ST_WORD)
    else $error("separator not followed by word");

endmodule

[hw/rtl/greedy_word_wrap.sv]
// Channel  Dir  Payload (low bit up)          Marks
// s_axis   in   tdata: in_byte[7:0]           tuser: command (0 text, 1 end of input)
// m_axis   out  tdata: out_byte[7:0]          tlast: last, tuser: too_long
// cfg      in   cfg_wdata_i: line_width[11:0] written when cfg_we_i is high
//
// A text byte that is not whitespace produces no output. A whitespace byte or end of
// input passes a planning state, then emits S separator (0 or 1), W buffered word
// bytes and T trailing newlines (0 to 2), one byte per cycle while m_axis_tready
// allows, through the single output register and the word store's one read port.
// Reset sets line_width to 80 and clears all counts and the error flag.
// A low m_axis_tready holds emission; input is taken only between items.
module greedy_word_wrap import gwr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LineW-1:0] cfg_wdata_i,    // line_width
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // in_byte
  input  logic             s_axis_tuser,   // command
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_byte
  output logic             m_axis_tlast,
  output logic             m_axis_tuser    // too_long
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  gwr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  gwr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gwr_pkg::*;

  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned SettleCycles  = 48;
  localparam int unsigned ReportMax     = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       too_long;
  } wrap_beat_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LineW-1:0] cfg_wdata_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [7:0]       m_axis_tdata;
  logic             m_axis_tlast;
  logic             m_axis_tuser;

  // wrapper state mirror
  logic [7:0]  word_buf [MaxWord];
  int unsigned word_cnt;
  int unsigned line_cnt;
  int unsigned lf_run;
  bit          sticky_err;
  int unsigned width_cfg;
  logic [7:0]  emit_q [$];

  wrap_beat_t  expected_beats [$];
  int unsigned bad_cnt;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  bit          idle_en;
  bit          hold_req;

  greedy_word_wrap dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit is_blank(logic [7:0] b);
    return (b == ChrSp) || (b >= ChrTab && b <= ChrCr);
  endfunction

  function automatic void grow_line(int unsigned n);
    int unsigned s;
    s = line_cnt + n;
    line_cnt = (s > 32'(LineMax)) ? 32'(LineMax) : s;
  endfunction

  // emit the buffered word with its separator
  function automatic void place_word();
    int unsigned i;
    if (word_cnt != 0) begin
      if (line_cnt != 0 && line_cnt + word_cnt >= width_cfg) begin
        emit_q.push_back(ChrLf);
        line_cnt = 0;
      end
      if (line_cnt != 0) begin
        emit_q.push_back(ChrSp);
        grow_line(1);
      end
      if (word_cnt > width_cfg) sticky_err = 1'b1;
      for (i = 0; i < word_cnt; i++) emit_q.push_back(word_buf[i]);
      grow_line(word_cnt);
      word_cnt = 0;
    end
  endfunction

  function automatic void predict_wrap(cmd_e cmd, logic [7:0] b);
    bit          flag;
    wrap_beat_t  beat;
    int unsigned k;
    emit_q.delete();
    if (cmd == CMD_END) begin
      place_word();
      emit_q.push_back(ChrLf);
      flag       = sticky_err;
      word_cnt   = 0;
      line_cnt   = 0;
      lf_run     = 0;
      sticky_err = 1'b0;
    end else if (is_blank(b)) begin
      place_word();
      if (b == ChrLf && lf_run < 3) lf_run++;
      if (lf_run == 2) begin
        emit_q.push_back(ChrLf);
        emit_q.push_back(ChrLf);
        lf_run   = 0;
        line_cnt = 0;
      end
      flag = sticky_err;
    end else begin
      if (word_cnt < MaxWord) begin
        word_buf[word_cnt] = b;
        word_cnt++;
      end else begin
        sticky_err = 1'b1;  // overflow byte dropped
      end
      lf_run = 0;
      flag   = sticky_err;
    end
    for (k = 0; k < emit_q.size(); k++) begin
      beat.data     = emit_q[k];
      beat.last     = (k == emit_q.size() - 1);
      beat.too_long = flag;
      expected_beats.push_back(beat);
    end
  endfunction

  task automatic send_item(input cmd_e cmd, input logic [7:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_wrap(cmd, data);
    items_sent++;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // only legal once the wrapper is quiet
  task automatic set_width(input int unsigned w);
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_wdata_i <= w[LineW-1:0];
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    width_cfg = w;
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) begin
      b = 8'h61 + 8'($urandom_range(0, 25));
    end else begin
      do b = 8'($urandom_range(0, 255)); while (is_blank(b));
    end
    return b;
  endfunction

  // words with random content and mixed separators, some noise
  task automatic send_stream(input int unsigned n_items, input bit long_first);
    int unsigned start;
    int unsigned len;
    int unsigned sel;
    bit          first;
    start = items_sent;
    first = long_first;
    while (items_sent - start < n_items) begin
      sel = $urandom_range(0, 11);
      if (first || sel == 0) len = $urandom_range(MaxWord, MaxWord + 8);
      else if (sel < 3) len = $urandom_range(10, MaxWord - 1);
      else len = $urandom_range(1, 9);
      first = 1'b0;
      repeat (len) send_item(CMD_TEXT, word_char());
      sel = $urandom_range(0, 19);
      case (sel)
        9, 10, 11: send_item(CMD_TEXT, ChrLf);
        12: repeat (2) send_item(CMD_TEXT, ChrLf);
        13: repeat (3) send_item(CMD_TEXT, ChrLf);
        14: send_item(CMD_TEXT, 8'($urandom_range(ChrTab, ChrCr)));
        15: repeat (2) send_item(CMD_TEXT, ChrSp);
        16: send_item(CMD_TEXT, 8'($urandom_range(0, 255)));
        17: send_item(CMD_END, 8'($urandom_range(0, 255)));
        default: send_item(CMD_TEXT, ChrSp);
      endcase
    end
  endtask

  // reset width; all blank kinds, blank lines, extreme bytes, flush at end
  task automatic test_directed();
    logic [7:0] seq [$];
    seq = {8'h61, 8'hFF, ChrSp, 8'h00, 8'h62, ChrTab, 8'h63, ChrLf, ChrLf, 8'h64,
           8'h0B, 8'h65, 8'h0C, ChrCr, ChrLf, ChrLf, ChrLf, 8'h66};
    foreach (seq[i]) send_item(CMD_TEXT, seq[i]);
    send_item(CMD_END, 8'hFF);
    send_item(CMD_TEXT, ChrSp);
    send_item(CMD_END, 8'h00);
  endtask

  task automatic test_narrow();
    set_width(1);
    send_stream(30, 1'b1);
  endtask

  task automatic test_zero_width();
    set_width(0);
    send_stream(15, 1'b0);
  endtask

  task automatic test_full_width();
    set_width(32'(LineMax));
    send_stream(15, 1'b0);
  endtask

  task automatic test_widths();
    repeat (4) begin
      set_width($urandom_range(2, 40));
      send_stream(10, 1'b0);
    end
  endtask

  task automatic test_backpressure();
    set_width($urandom_range(5, 20));
    hold_req = 1'b1;
    send_stream(25, 1'b0);
  endtask

  task automatic test_steady();
    set_width(16);
    idle_en = 1'b0;
    send_stream(20, 1'b0);
  endtask

  // receiver: random stalls, one long hold on request
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    stall_left    = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk_i) begin
    wrap_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= ReportMax) $display("unexpected output byte %02h", m_axis_tdata);
      end else begin
        want = expected_beats.pop_front();
        if (m_axis_tdata !== want.data || m_axis_tlast !== want.last ||
            m_axis_tuser !== want.too_long) begin
          bad_cnt++;
          if (bad_cnt <= ReportMax)
            $display({"output mismatch: expected %02h last %0b too_long %0b, ",
                      "got %02h last %0b too_long %0b"},
                     want.data, want.last, want.too_long,
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TEXT;
    word_cnt      = 0;
    line_cnt      = 0;
    lf_run        = 0;
    sticky_err    = 1'b0;
    width_cfg     = 32'(LineWidthRst);
    bad_cnt       = 0;
    items_sent    = 0;
    quiet_cycles  = 0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_narrow();
    test_zero_width();
    test_full_width();
    test_widths();
    test_backpressure();
    test_steady();

    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (bad_cnt == 0 && expected_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (expected_beats.size() != 0)
        $display("%0d expected output bytes never arrived", expected_beats.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/gwr_pkg.sv
hw/rtl/gwr_datapath.sv
hw/rtl/gwr_ctrl.sv
hw/rtl/greedy_word_wrap.sv
verif/tb_top.sv
